### hdl/bsd_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsd_pkg: shared types and constants for the Base64 stream decoder
// Character codes, the sextet mapping and the item and result records.
// ---------------------------------------------------------------------------
package bsd_pkg;

    // Character codes
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
    localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHAR_PLUS    = 8'h2b;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;
    localparam logic [7:0] CHAR_UNDER   = 8'h5f;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3d;
    localparam logic [7:0] CHAR_PERIOD  = 8'h2e;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0a;

    // Offsets of the lower-case and digit ranges in the alphabet
    localparam logic [7:0] LOWER_BASE = 8'd26;
    localparam logic [7:0] DIGIT_BASE = 8'd52;
    localparam logic [5:0] SEXTET_62  = 6'd62;
    localparam logic [5:0] SEXTET_63  = 6'd63;

    // Slot positions within a four-character group
    localparam logic [1:0] SLOT_0 = 2'd0;
    localparam logic [1:0] SLOT_1 = 2'd1;
    localparam logic [1:0] SLOT_2 = 2'd2;
    localparam logic [1:0] SLOT_3 = 2'd3;

    // One input item
    typedef struct packed {
        logic [7:0] char_in;
        logic       end_of_text;
    } in_item_t;

    // One result item
    typedef struct packed {
        logic [7:0] byte_out;
        logic       has_byte;
        logic       last;
        logic       truncated;
    } result_t;

    // Map a character to its 6-bit value; unknown characters give zero
    function automatic logic [5:0] sextet_of(input logic [7:0] c);
        logic [5:0] s;
        begin
            s = 6'd0;
            if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
            begin
                s = 6'(c - CHAR_UPPER_A);
            end
            else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
            begin
                s = 6'(c - CHAR_LOWER_A + LOWER_BASE);
            end
            else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9)
            begin
                s = 6'(c - CHAR_DIGIT_0 + DIGIT_BASE);
            end
            else if (c == CHAR_PLUS || c == CHAR_MINUS)
            begin
                s = SEXTET_62;
            end
            else if (c == CHAR_SLASH || c == CHAR_UNDER)
            begin
                s = SEXTET_63;
            end
            return s;
        end
    endfunction

    // Pad characters
    function automatic logic is_pad(input logic [7:0] c);
        begin
            return (c == CHAR_EQUALS) || (c == CHAR_PERIOD);
        end
    endfunction

endpackage
`default_nettype wire

### hdl/bsd_in_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsd_in_stage: input register
// Captures one character per transfer and holds it until the decoder
// moves it on.
// ---------------------------------------------------------------------------
module bsd_in_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire bsd_pkg::in_item_t in_item,
    input  wire logic             advance,
    output logic                  item_valid,
    output bsd_pkg::in_item_t     item
);

    logic              valid_reg;
    logic              valid_next;
    bsd_pkg::in_item_t item_reg;
    logic              load;

    // Stall while the held item cannot move on
    assign in_stall = valid_reg && !advance;
    assign load     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

### hdl/bsd_decode.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsd_decode: group state and byte assembly
// Maps the held character, forms the byte for its slot and updates the
// slot, previous sextet and pad flag when the item moves on.
// ---------------------------------------------------------------------------
module bsd_decode
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              skip_newlines,
    input  wire logic              item_valid,
    input  wire bsd_pkg::in_item_t item,
    input  wire logic              advance,
    output logic                   emit,
    output bsd_pkg::result_t       result
);

    logic [1:0] slot_reg;
    logic [1:0] slot_next;
    logic [5:0] prior_reg;
    logic [5:0] prior_next;
    logic       pad_seen_reg;
    logic       pad_seen_next;

    logic       keep;
    logic       pad;
    logic       has;
    logic [7:0] byte_val;
    logic [5:0] s;

    assign keep = !(skip_newlines && item.char_in == bsd_pkg::CHAR_NEWLINE);
    assign s    = bsd_pkg::sextet_of(item.char_in);
    assign pad  = bsd_pkg::is_pad(item.char_in);

    // Byte assembly and next state
    always_comb
    begin
        has           = 1'b0;
        byte_val      = 8'd0;
        slot_next     = slot_reg;
        prior_next    = prior_reg;
        pad_seen_next = pad_seen_reg;
        if (keep)
        begin
            case (slot_reg)
                bsd_pkg::SLOT_0:
                begin
                    pad_seen_next = 1'b0;
                end
                bsd_pkg::SLOT_1:
                begin
                    byte_val = {prior_reg, s[5:4]};
                    has      = 1'b1;
                end
                bsd_pkg::SLOT_2:
                begin
                    if (pad)
                    begin
                        pad_seen_next = 1'b1;
                    end
                    else
                    begin
                        byte_val = {prior_reg[3:0], s[5:2]};
                        has      = 1'b1;
                    end
                end
                default:
                begin
                    if (!pad_seen_reg && !pad)
                    begin
                        byte_val = {prior_reg[1:0], s};
                        has      = 1'b1;
                    end
                    pad_seen_next = 1'b0;
                end
            endcase
            prior_next = s;
            slot_next  = slot_reg + 2'd1;
        end

        result.byte_out  = byte_val;
        result.has_byte  = has;
        result.last      = item.end_of_text;
        // A lone character in slot 0 leaves the next slot at one
        result.truncated = item.end_of_text && (slot_next == bsd_pkg::SLOT_1);

        // End of stream returns all state to reset
        if (item.end_of_text)
        begin
            slot_next     = bsd_pkg::SLOT_0;
            prior_next    = 6'd0;
            pad_seen_next = 1'b0;
        end

        emit = item_valid && (has || item.end_of_text);
    end

    // Group state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg     <= bsd_pkg::SLOT_0;
            prior_reg    <= 6'd0;
            pad_seen_reg <= 1'b0;
        end
        else if (advance)
        begin
            slot_reg     <= slot_next;
            prior_reg    <= prior_next;
            pad_seen_reg <= pad_seen_next;
        end
    end

endmodule
`default_nettype wire

### hdl/bsd_out_stage.sv
`default_nettype none
// ---------------------------------------------------------------------------
// bsd_out_stage: result register
// Holds one decoded result until the downstream side takes the transfer.
// ---------------------------------------------------------------------------
module bsd_out_stage
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire bsd_pkg::result_t result_in,
    output logic                  out_free,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output bsd_pkg::result_t      result_out
);

    logic             valid_reg;
    logic             valid_next;
    bsd_pkg::result_t result_reg;

    // Room when empty or when the held result leaves this cycle
    assign out_free = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign out_valid  = valid_reg;
    assign result_out = result_reg;

endmodule
`default_nettype wire

### hdl/base64_stream_decoder.sv
`default_nettype none
// ---------------------------------------------------------------------------
// base64_stream_decoder: streaming Base64 character decoder
// One character in per transfer, at most one decoded byte out per character.
// ---------------------------------------------------------------------------
// The block takes one character per clock cycle while neither side stalls.
// The character sits in an input register, the slot logic forms the byte
// and updates the group state (slot, previous sextet, pad flag), whose loop
// closes within that logic and sets the rate, and the byte waits in a result
// register. Characters that give no byte leave no result; a character marked
// end_of_text always gives one result with last set, and truncated set when
// a lone character was left in slot 0. skip_newlines drops line feeds before
// decoding; it is to be written by the user only while the block is idle,
// and the block itself does not enforce this.
module base64_stream_decoder
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write_en,
    input  wire logic       cfg_write_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] char_in,
    input  wire logic       end_of_text,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      byte_out,
    output logic            has_byte,
    output logic            last,
    output logic            truncated
);

    logic              skip_newlines_reg;
    bsd_pkg::in_item_t in_item;
    bsd_pkg::in_item_t item;
    logic              item_valid;
    logic              advance;
    logic              emit;
    logic              out_free;
    bsd_pkg::result_t  result;
    bsd_pkg::result_t  result_out;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_newlines_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            skip_newlines_reg <= cfg_write_data;
        end
    end

    assign in_item.char_in     = char_in;
    assign in_item.end_of_text = end_of_text;

    // Items without a result move on even when the result register is full
    assign advance = item_valid && (!emit || out_free);

    bsd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    bsd_decode u_decode
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .skip_newlines (skip_newlines_reg),
        .item_valid    (item_valid),
        .item          (item),
        .advance       (advance),
        .emit          (emit),
        .result        (result)
    );

    bsd_out_stage u_out_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance && emit),
        .result_in  (result),
        .out_free   (out_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .result_out (result_out)
    );

    assign byte_out  = result_out.byte_out;
    assign has_byte  = result_out.has_byte;
    assign last      = result_out.last;
    assign truncated = result_out.truncated;

endmodule
`default_nettype wire

### sim/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: self-checking testbench for base64_stream_decoder
// Drives Base64 character streams through the decoder with random sender
// gaps and receiver stalls, predicts every decoded byte and end marker in
// a behavioral decoder of its own, and compares each result field by field.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 8;
    localparam int DRAIN_TAIL     = 4;     // pipeline is two stages deep
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int BURST_MAX      = 12;

    // DUT interface
    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       cfg_write_en   = 1'b0;
    logic       cfg_write_data = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_stall;
    logic [7:0] char_in        = 8'h00;
    logic       end_of_text    = 1'b0;
    logic       out_valid;
    logic       out_stall      = 1'b0;
    logic [7:0] byte_out;
    logic       has_byte;
    logic       last;
    logic       truncated;

    // Decoder prediction state
    logic              skip_nl      = 1'b0;
    logic [1:0]        grp_slot     = bsd_pkg::SLOT_0;
    logic [5:0]        prev_sextet  = 6'd0;
    logic              pad_in_group = 1'b0;
    bsd_pkg::result_t  decoded_fifo[$];
    bsd_pkg::result_t  want;

    // Traffic shaping
    int unsigned gap_max    = 4;
    logic        stall_on   = 1'b1;
    logic        stalling   = 1'b0;
    int unsigned stall_run  = 0;
    int unsigned burst_left = 0;

    // Bookkeeping
    int errors           = 0;
    int chars_decoded    = 0;
    int newlines_dropped = 0;
    int streams_sent     = 0;
    int results_checked  = 0;
    int truncations      = 0;
    int quiet_cycles     = 0;

    base64_stream_decoder u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .char_in        (char_in),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .byte_out       (byte_out),
        .has_byte       (has_byte),
        .last           (last),
        .truncated      (truncated)
    );

    // Clock
    initial
    begin
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // ---------------------------------------------------------------
    // Behavioral decoder
    // ---------------------------------------------------------------

    // 6-bit value of a character; anything outside the alphabet is zero
    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [5:0] v;
        begin
            v = 6'd0;
            if (c >= bsd_pkg::CHAR_UPPER_A && c <= bsd_pkg::CHAR_UPPER_Z)
                v = 6'(c - bsd_pkg::CHAR_UPPER_A);
            else if (c >= bsd_pkg::CHAR_LOWER_A && c <= bsd_pkg::CHAR_LOWER_Z)
                v = 6'(c - bsd_pkg::CHAR_LOWER_A + 8'd26);
            else if (c >= bsd_pkg::CHAR_DIGIT_0 && c <= bsd_pkg::CHAR_DIGIT_9)
                v = 6'(c - bsd_pkg::CHAR_DIGIT_0 + 8'd52);
            else if (c == bsd_pkg::CHAR_PLUS || c == bsd_pkg::CHAR_MINUS)
                v = 6'd62;
            else if (c == bsd_pkg::CHAR_SLASH || c == bsd_pkg::CHAR_UNDER)
                v = 6'd63;
            return v;
        end
    endfunction

    function automatic logic is_pad_char(input logic [7:0] c);
        begin
            return c == bsd_pkg::CHAR_EQUALS || c == bsd_pkg::CHAR_PERIOD;
        end
    endfunction

    // Advance the group state by one accepted character; returns 1 when a
    // result is due and fills it in
    function automatic logic decode_char(input logic [7:0] c, input logic eot,
                                         output bsd_pkg::result_t r);
        logic [5:0] v;
        logic [7:0] b;
        logic       got;
        logic       trunc;
        begin
            b     = 8'h00;
            got   = 1'b0;
            trunc = 1'b0;
            if (!(skip_nl && c == bsd_pkg::CHAR_NEWLINE))
            begin
                v = char_value(c);
                case (grp_slot)
                    bsd_pkg::SLOT_0:
                    begin
                        pad_in_group = 1'b0;
                    end
                    bsd_pkg::SLOT_1:
                    begin
                        b   = {prev_sextet, v[5:4]};
                        got = 1'b1;
                    end
                    bsd_pkg::SLOT_2:
                    begin
                        if (is_pad_char(c))
                        begin
                            pad_in_group = 1'b1;
                        end
                        else
                        begin
                            b   = {prev_sextet[3:0], v[5:2]};
                            got = 1'b1;
                        end
                    end
                    default:
                    begin
                        if (!pad_in_group && !is_pad_char(c))
                        begin
                            b   = {prev_sextet[1:0], v};
                            got = 1'b1;
                        end
                        pad_in_group = 1'b0;
                    end
                endcase
                prev_sextet = v;
                grp_slot    = grp_slot + 2'd1;
            end
            // end of stream: close with a marker and clear the group
            if (eot)
            begin
                trunc        = (grp_slot == bsd_pkg::SLOT_1);
                grp_slot     = bsd_pkg::SLOT_0;
                prev_sextet  = 6'd0;
                pad_in_group = 1'b0;
            end
            r.byte_out  = b;
            r.has_byte  = got;
            r.last      = eot;
            r.truncated = trunc;
            return got || eot;
        end
    endfunction

    // Random alphabet character, picking either spelling of 62 and 63 at random
    function automatic logic [7:0] alphabet_char(input int unsigned v);
        logic [7:0] c;
        begin
            if (v < 26)
                c = bsd_pkg::CHAR_UPPER_A + 8'(v);
            else if (v < 52)
                c = bsd_pkg::CHAR_LOWER_A + 8'(v - 26);
            else if (v < 62)
                c = bsd_pkg::CHAR_DIGIT_0 + 8'(v - 52);
            else if (v == 62)
                c = $urandom_range(0, 1) ? bsd_pkg::CHAR_PLUS : bsd_pkg::CHAR_MINUS;
            else
                c = $urandom_range(0, 1) ? bsd_pkg::CHAR_SLASH : bsd_pkg::CHAR_UNDER;
            return c;
        end
    endfunction

    // ---------------------------------------------------------------
    // Driving
    // ---------------------------------------------------------------

    // One input transfer; valid stays high within a burst
    task automatic send_char(input logic [7:0] c, input logic eot);
        bsd_pkg::result_t r;
        int unsigned      gap;
        begin
            if (burst_left == 0)
            begin
                gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                if (gap != 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                burst_left = $urandom_range(1, BURST_MAX);
            end
            burst_left--;
            in_valid    <= 1'b1;
            char_in     <= c;
            end_of_text <= eot;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            if (skip_nl && c == bsd_pkg::CHAR_NEWLINE)
                newlines_dropped++;
            else
                chars_decoded++;
            if (eot)
                streams_sent++;
            if (decode_char(c, eot, r))
                decoded_fifo = {decoded_fifo, r};
        end
    endtask

    task automatic send_text(input string s, input logic closes);
        int i;
        begin
            for (i = 0; i < s.len(); i++)
                send_char(s[i], closes && i == s.len() - 1);
        end
    endtask

    // Stop sending and wait for every predicted result to come out
    task automatic wait_for_results;
        begin
            in_valid <= 1'b0;
            while (decoded_fifo.size() != 0)
                @(posedge clk);
        end
    endtask

    // Full drain: results out, then let characters that give none retire
    task automatic drain_decoder;
        begin
            wait_for_results();
            repeat (DRAIN_TAIL) @(posedge clk);
        end
    endtask

    task automatic write_skip_newlines(input logic v);
        begin
            cfg_write_en   <= 1'b1;
            cfg_write_data <= v;
            @(posedge clk);
            cfg_write_en <= 1'b0;
            skip_nl = v;
        end
    endtask

    // One encoded string: whole groups, then a random ending (padded,
    // unpadded or cut short), optional line feeds and corrupted bytes
    task automatic send_stream(input logic add_newlines, input logic add_noise);
        logic [7:0]  text[$];
        logic [7:0]  pad;
        int unsigned n_groups;
        int unsigned ending;
        int unsigned extra;
        logic        nl_end;
        int          i;
        begin
            n_groups = $urandom_range(0, 5);
            for (i = 0; i < 4 * n_groups; i++)
                text = {text, alphabet_char($urandom_range(0, 63))};
            pad    = $urandom_range(0, 1) ? bsd_pkg::CHAR_EQUALS : bsd_pkg::CHAR_PERIOD;
            ending = $urandom_range(0, 7);
            case (ending)
                2, 5:    extra = 2;
                3, 6:    extra = 3;
                4:       extra = 1;
                default: extra = 0;
            endcase
            for (i = 0; i < extra; i++)
                text = {text, alphabet_char($urandom_range(0, 63))};
            // two-pad ending; the slot after a slot-2 pad is ignored
            if (ending == 2)
            begin
                text = {text, pad};
                text = {text, ($urandom_range(0, 1) ? pad :
                               alphabet_char($urandom_range(0, 63)))};
            end
            if (ending == 3)
                text = {text, pad};
            if (text.size() == 0)
                text = {text, alphabet_char($urandom_range(0, 63))};
            if (add_noise)
            begin
                for (i = 0; i < text.size(); i++)
                    if ($urandom_range(0, 9) == 0)
                        text[i] = 8'($urandom_range(0, 255));
            end
            nl_end = add_newlines && $urandom_range(0, 7) == 0;
            for (i = 0; i < text.size(); i++)
            begin
                if (add_newlines && $urandom_range(0, 5) == 0)
                    send_char(bsd_pkg::CHAR_NEWLINE, 1'b0);
                send_char(text[i], !nl_end && i == text.size() - 1);
            end
            if (nl_end)
                send_char(bsd_pkg::CHAR_NEWLINE, 1'b1);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver stall pattern: alternating open and stalled runs
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_run == 0)
        begin
            stalling  = !stalling;
            stall_run = stalling ? $urandom_range(1, 5) : $urandom_range(1, 10);
        end
        stall_run--;
        out_stall <= stall_on && stalling;
    end

    // ---------------------------------------------------------------
    // Result checking
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        begin
            if (act_v !== exp_v)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %h actual %h",
                         $time, name, exp_v, act_v);
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (decoded_fifo.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual %h/%b/%b/%b",
                         $time, byte_out, has_byte, last, truncated);
            end
            else
            begin
                want = decoded_fifo.pop_front();
                results_checked++;
                if (want.truncated)
                    truncations++;
                check_field("byte_out", want.byte_out, byte_out);
                check_field("has_byte", 8'(want.has_byte), 8'(has_byte));
                check_field("last", 8'(want.last), 8'(last));
                check_field("truncated", 8'(want.truncated), 8'(truncated));
            end
        end
    end

    // Watchdog: no transfer on either side for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("base64_stream_decoder verification failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Pads in every slot, alphabet extremes, lone final character, empty
    // and newline-terminated streams
    task automatic test_directed;
        begin
            write_skip_newlines(1'b0);
            send_text("TWF=", 1'b1);        // pad in slot 3
            send_text("AQ==", 1'b1);        // pad in slot 2, slot 3 ignored
            send_text("=.-_", 1'b1);        // pads in slots 0 and 1 decode as 0
            send_text("Za9+z0/", 1'b0);
            send_char(8'hff, 1'b0);
            send_char(8'h00, 1'b1);         // lone character in slot 0
            drain_decoder();
            write_skip_newlines(1'b1);
            send_text("\n", 1'b1);          // nothing kept
            send_text("Q\n", 1'b1);         // dropped line feed closes stream
            drain_decoder();
        end
    endtask

    // Encoded strings with random content, some with corrupted bytes, under both settings
    task automatic test_well_formed_streams;
        int target;
        begin
            write_skip_newlines(1'b1);
            target = chars_decoded + 350;
            while (chars_decoded < target)
                send_stream(1'b1, $urandom_range(0, 3) == 0);
            drain_decoder();
            write_skip_newlines(1'b0);
            target = chars_decoded + 350;
            while (chars_decoded < target)
                send_stream(1'b0, $urandom_range(0, 3) == 0);
            drain_decoder();
        end
    endtask

    // Arbitrary bytes with scattered end markers
    task automatic test_noise;
        int          target;
        int unsigned pick;
        logic [7:0]  c;
        int          pass_no;
        begin
            for (pass_no = 0; pass_no < 2; pass_no++)
            begin
                write_skip_newlines(pass_no == 1);
                target = chars_decoded + 150;
                while (chars_decoded < target)
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                        c = alphabet_char($urandom_range(0, 63));
                    else if (pick < 7)
                    begin
                        case ($urandom_range(0, 2))
                            0:       c = bsd_pkg::CHAR_EQUALS;
                            1:       c = bsd_pkg::CHAR_PERIOD;
                            default: c = bsd_pkg::CHAR_NEWLINE;
                        endcase
                    end
                    else
                        c = 8'($urandom_range(0, 255));
                    send_char(c, $urandom_range(0, 11) == 0);
                end
                drain_decoder();
            end
        end
    endtask

    // Full rate: no sender gaps, no receiver stalls
    task automatic test_back_to_back;
        int target;
        begin
            gap_max  = 0;
            stall_on = 1'b0;
            write_skip_newlines(1'b1);
            target = chars_decoded + 250;
            while (chars_decoded < target)
                send_stream(1'b1, 1'b0);
            drain_decoder();
            gap_max  = 4;
            stall_on = 1'b1;
        end
    endtask

    // Sender holds off mid-stream until every predicted result has come out
    task automatic test_pause_midstream;
        int round;
        int i;
        begin
            for (round = 0; round < 4; round++)
            begin
                for (i = 0; i < 6 + round; i++)
                    send_char(alphabet_char($urandom_range(0, 63)), 1'b0);
                wait_for_results();
                send_char(alphabet_char($urandom_range(0, 63)), 1'b0);
                send_char(alphabet_char($urandom_range(0, 63)), 1'b1);
            end
            drain_decoder();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_well_formed_streams();
        test_noise();
        test_back_to_back();
        test_pause_midstream();
        drain_decoder();

        if (decoded_fifo.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived",
                     $time, decoded_fifo.size());
        end

        $display("Sent %0d decoded characters and %0d dropped line feeds in %0d streams",
                 chars_decoded, newlines_dropped, streams_sent);
        $display("Checked %0d results (%0d truncated endings), %0d mismatches",
                 results_checked, truncations, errors);
        if (errors == 0)
        begin
            $display("base64_stream_decoder verification clean");
        end
        else
        begin
            $display("base64_stream_decoder verification failed");
        end
        $finish;
    end

endmodule
